FILE: sv/layered_grid_manhattan_path_top_assert.svh
// assertion macros for the layered grid manhattan path block
`ifndef LAYERED_GRID_MANHATTAN_PATH_TOP_ASSERT_SVH
`define LAYERED_GRID_MANHATTAN_PATH_TOP_ASSERT_SVH

// same-cycle implication, reset gated
`define LGMP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset gated
`define LGMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lgmp_pkg.sv
// ----------------------------------------------------------------------------
// lgmp_pkg
// shared types and constants of the layered grid manhattan path block
// ----------------------------------------------------------------------------
package lgmp_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DIM_W     = 7;
    localparam int LABEL_W   = 13;
    localparam int COST_W    = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [COST_W-1:0] SAT_COST = '1;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd2;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0] distance;
        logic              reachable;
    } out_item_t;

    // grid geometry and load status seen by the sequencer
    typedef struct packed {
        logic [DIM_W-1:0]   nr;
        logic [DIM_W-1:0]   nc;
        logic [CNT_W-1:0]   n;
        logic [LABEL_W-1:0] p;
        logic [CNT_W-1:0]   load_cnt;
    } grid_info_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] distance;
        logic              reachable;
    } result_t;

    typedef enum logic {
        T_LOAD,
        T_RUN
    } top_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_RD0,
        C_RD1,
        C_UPD,
        C_RESULT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_FWD,
        PH_BWD,
        PH_FIND
    } phase_t;

endpackage

FILE: sv/lgmp_ram.sv
// ----------------------------------------------------------------------------
// lgmp_ram
// single write, single registered read memory
// ----------------------------------------------------------------------------
module lgmp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/lgmp_min_unit.sv
// ----------------------------------------------------------------------------
// lgmp_min_unit
// shared relax unit: min of a base cost and two saturating neighbor steps
// ----------------------------------------------------------------------------
module lgmp_min_unit (
    input  logic [lgmp_pkg::COST_W-1:0] base,
    input  logic [lgmp_pkg::COST_W-1:0] vert,
    input  logic                        vert_en,
    input  logic [lgmp_pkg::COST_W-1:0] horiz,
    input  logic                        horiz_en,
    output logic [lgmp_pkg::COST_W-1:0] result
);
    import lgmp_pkg::*;

    logic [COST_W-1:0] vert_inc;
    logic [COST_W-1:0] horiz_inc;
    logic [COST_W-1:0] m0;

    assign vert_inc  = (vert == SAT_COST) ? SAT_COST : vert + COST_W'(1);
    assign horiz_inc = (horiz == SAT_COST) ? SAT_COST : horiz + COST_W'(1);

    always_comb begin
        m0 = base;
        if (vert_en && vert_inc < m0) begin
            m0 = vert_inc;
        end
        result = m0;
        if (horiz_en && horiz_inc < m0) begin
            result = horiz_inc;
        end
    end

endmodule

FILE: sv/lgmp_ctrl.sv
// ----------------------------------------------------------------------------
// lgmp_ctrl
// sweep sequencer: per level a forward and a backward raster pass, then a goal scan
// ----------------------------------------------------------------------------
`include "layered_grid_manhattan_path_top_assert.svh"

module lgmp_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  lgmp_pkg::grid_info_t         info,
    output logic [lgmp_pkg::ADDR_W-1:0]  label_raddr,
    input  logic [lgmp_pkg::LABEL_W-1:0] label_rdata,
    output lgmp_pkg::result_t            res,
    input  logic                         res_ack
);
    import lgmp_pkg::*;

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;

    logic [ADDR_W-1:0]  k_reg, k_next;
    logic [ROW_W-1:0]   r_reg, r_next;
    logic [COL_W-1:0]   c_reg, c_next;
    logic [LABEL_W-1:0] v_reg, v_next;
    logic               found_reg, found_next;
    logic [COST_W-1:0]  prev_reg, prev_next;
    logic [COST_W-1:0]  cost_k_reg, cost_k_next;
    logic [LABEL_W-1:0] lab_k_reg, lab_k_next;
    logic [COST_W-1:0]  dist_reg, dist_next;
    logic               reach_reg, reach_next;

    logic [ADDR_W-1:0]  cost_raddr;
    logic [COST_W-1:0]  cost_rdata;
    logic               cost_we;
    logic [COST_W-1:0]  cost_wdata;

    logic [LABEL_W-1:0] lab_eff;
    logic [COST_W-1:0]  rc_cost;
    logic [COST_W-1:0]  base;
    logic               vert_en;
    logic               horiz_en;
    logic [COST_W-1:0]  relaxed;
    logic               last_cell;

    lgmp_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost_ram (
        .aclk  (aclk),
        .we    (cost_we),
        .waddr (k_reg),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    lgmp_min_unit u_min (
        .base     (base),
        .vert     (cost_rdata),
        .vert_en  (vert_en),
        .horiz    (prev_reg),
        .horiz_en (horiz_en),
        .result   (relaxed)
    );

    // cells past the loaded count carry no level
    assign lab_eff   = (CNT_W'(k_reg) < info.load_cnt) ? lab_k_reg : '0;
    assign rc_cost   = COST_W'(r_reg) + COST_W'(c_reg);
    assign last_cell = (CNT_W'(k_reg) == info.n - CNT_W'(1));
    assign cost_wdata = relaxed;

    always_comb begin
        base     = cost_k_reg;
        vert_en  = 1'b0;
        horiz_en = 1'b0;
        unique case (phase_reg)
            PH_FWD: begin
                if (lab_eff != v_reg) begin
                    base = SAT_COST;
                end else if (v_reg == LABEL_W'(1)) begin
                    base = rc_cost;
                end
                vert_en  = (r_reg != '0);
                horiz_en = (c_reg != '0);
            end
            PH_BWD: begin
                vert_en  = (DIM_W'(r_reg) + DIM_W'(1) < info.nr);
                horiz_en = (DIM_W'(c_reg) + DIM_W'(1) < info.nc);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            phase_reg <= PH_FWD;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        v_reg      <= v_next;
        found_reg  <= found_next;
        prev_reg   <= prev_next;
        cost_k_reg <= cost_k_next;
        lab_k_reg  <= lab_k_next;
        dist_reg   <= dist_next;
        reach_reg  <= reach_next;
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        k_next      = k_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        v_next      = v_reg;
        found_next  = found_reg;
        prev_next   = prev_reg;
        cost_k_next = cost_k_reg;
        lab_k_next  = lab_k_reg;
        dist_next   = dist_reg;
        reach_next  = reach_reg;
        cost_raddr  = k_reg;
        label_raddr = k_reg;
        cost_we     = 1'b0;

        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    k_next     = '0;
                    r_next     = '0;
                    c_next     = '0;
                    v_next     = LABEL_W'(1);
                    found_next = 1'b0;
                    phase_next = (info.p == LABEL_W'(1)) ? PH_FIND : PH_FWD;
                    state_next = C_RD0;
                end
            end
            C_RD0: begin
                state_next = C_RD1;
            end
            C_RD1: begin
                cost_k_next = cost_rdata;
                lab_k_next  = label_rdata;
                cost_raddr  = (phase_reg == PH_BWD) ? k_reg + ADDR_W'(info.nc)
                                                    : k_reg - ADDR_W'(info.nc);
                state_next  = C_UPD;
            end
            C_UPD: begin
                state_next = C_RD0;
                unique case (phase_reg)
                    PH_FWD: begin
                        cost_we   = 1'b1;
                        prev_next = relaxed;
                        if (lab_eff == v_reg) begin
                            found_next = 1'b1;
                        end
                        if (last_cell) begin
                            if (!(found_reg || lab_eff == v_reg)) begin
                                dist_next  = SAT_COST;
                                reach_next = 1'b0;
                                state_next = C_RESULT;
                            end else begin
                                phase_next = PH_BWD;
                                r_next     = ROW_W'(info.nr - DIM_W'(1));
                                c_next     = COL_W'(info.nc - DIM_W'(1));
                            end
                        end else begin
                            k_next = k_reg + ADDR_W'(1);
                            if (DIM_W'(c_reg) + DIM_W'(1) == info.nc) begin
                                c_next = '0;
                                r_next = r_reg + ROW_W'(1);
                            end else begin
                                c_next = c_reg + COL_W'(1);
                            end
                        end
                    end
                    PH_BWD: begin
                        cost_we   = 1'b1;
                        prev_next = relaxed;
                        if (k_reg == '0) begin
                            v_next     = v_reg + LABEL_W'(1);
                            found_next = 1'b0;
                            r_next     = '0;
                            c_next     = '0;
                            phase_next = (v_reg + LABEL_W'(1) == info.p) ? PH_FIND : PH_FWD;
                        end else begin
                            k_next = k_reg - ADDR_W'(1);
                            if (c_reg == '0) begin
                                c_next = COL_W'(info.nc - DIM_W'(1));
                                r_next = r_reg - ROW_W'(1);
                            end else begin
                                c_next = c_reg - COL_W'(1);
                            end
                        end
                    end
                    default: begin
                        if (lab_eff == info.p) begin
                            dist_next  = (info.p == LABEL_W'(1)) ? rc_cost : cost_k_reg;
                            reach_next = 1'b1;
                            state_next = C_RESULT;
                        end else if (last_cell) begin
                            dist_next  = SAT_COST;
                            reach_next = 1'b0;
                            state_next = C_RESULT;
                        end else begin
                            k_next = k_reg + ADDR_W'(1);
                            if (DIM_W'(c_reg) + DIM_W'(1) == info.nc) begin
                                c_next = '0;
                                r_next = r_reg + ROW_W'(1);
                            end else begin
                                c_next = c_reg + COL_W'(1);
                            end
                        end
                    end
                endcase
            end
            C_RESULT: begin
                if (res_ack) begin
                    state_next = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign res.valid     = (state_reg == C_RESULT);
    assign res.distance  = dist_reg;
    assign res.reachable = reach_reg;

    `LGMP_ASSERT_IMPLY(a_we_in_update, aclk, aresetn, cost_we, (state_reg == C_UPD) && (phase_reg != PH_FIND), "cost write outside an update step")
    `LGMP_ASSERT_IMPLY(a_we_in_grid, aclk, aresetn, cost_we, CNT_W'(k_reg) < info.n, "cost write beyond the grid")
    `LGMP_ASSERT_NEXT(a_res_holds, aclk, aresetn, res.valid && !res_ack, res.valid, "result dropped before ack")
    `LGMP_ASSERT_IMPLY(a_reach_sat, aclk, aresetn, res.valid && !res.reachable, res.distance == SAT_COST, "unreachable result without saturated distance")

endmodule

FILE: sv/layered_grid_manhattan_path_top.sv
// ----------------------------------------------------------------------------
// layered_grid_manhattan_path_top
// layered manhattan distance transform over a labelled grid
// ----------------------------------------------------------------------------
// Cells stream in on s_ one label per transaction in raster order, one cell
// per cycle, and are stored in an on-chip label memory; cells beyond
// rows*cols are dropped. The transaction with last set closes the grid and
// starts the compute phase, during which s_ready is low. Compute runs one
// shared relax unit over a cost memory with one write port and one
// registered read port: every cell visit steps through read cell, read
// vertical neighbor, relax and write. Each level 1..p-1 takes a forward
// and a backward raster pass, then one scan finds the first goal cell. A
// missing level is detected at the end of its forward pass, which ends the
// run early with an unreachable, saturated result. One result
// transaction per grid leaves on m_ through an output register, so the next
// grid may start loading while the result waits. Configuration writes are
// taken on cfg_ at any time and are expected only between grids.
// ----------------------------------------------------------------------------
module layered_grid_manhattan_path_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // cell input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lgmp_pkg::in_item_t             s_data,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output lgmp_pkg::out_item_t            m_data,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lgmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgmp_pkg::LABEL_W-1:0]   cfg_data
);
    import lgmp_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   cols_reg;
    logic [LABEL_W-1:0] levels_reg;

    // load side
    top_state_t         tstate_reg, tstate_next;
    logic [CNT_W-1:0]   load_cnt_reg, load_cnt_next;
    logic               s_accept;
    logic               label_we;

    // result register
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    // effective geometry after clamping
    logic [DIM_W-1:0]   nr;
    logic [DIM_W-1:0]   nc;
    grid_info_t         info;

    logic [ADDR_W-1:0]  label_raddr;
    logic [LABEL_W-1:0] label_rdata;
    result_t            res;
    logic               res_ack;
    logic               start;

    // a zero dimension acts as one, oversize ones clamp to the maximum
    always_comb begin
        nr = rows_reg;
        if (rows_reg == '0) begin
            nr = DIM_W'(1);
        end else if (rows_reg > DIM_W'(MAX_ROWS)) begin
            nr = DIM_W'(MAX_ROWS);
        end
        nc = cols_reg;
        if (cols_reg == '0) begin
            nc = DIM_W'(1);
        end else if (cols_reg > DIM_W'(MAX_COLS)) begin
            nc = DIM_W'(MAX_COLS);
        end
    end

    assign info.nr       = nr;
    assign info.nc       = nc;
    assign info.n        = CNT_W'(nr) * CNT_W'(nc);
    assign info.p        = (levels_reg == '0) ? LABEL_W'(1) : levels_reg;
    assign info.load_cnt = load_cnt_reg;

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   <= DIM_W'(64);
            cols_reg   <= DIM_W'(64);
            levels_reg <= LABEL_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROWS:   rows_reg   <= cfg_data[DIM_W-1:0];
                REG_COLS:   cols_reg   <= cfg_data[DIM_W-1:0];
                REG_LEVELS: levels_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // loading: one cell per transaction while in the load state
    assign s_ready  = (tstate_reg == T_LOAD);
    assign s_accept = s_valid && s_ready;
    assign label_we = s_accept && (load_cnt_reg < info.n);
    assign start    = s_accept && s_data.last;

    // result hands over when the output register is free or draining
    assign res_ack = res.valid && (!m_valid_reg || m_ready);

    always_comb begin
        tstate_next   = tstate_reg;
        load_cnt_next = load_cnt_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (tstate_reg)
            T_LOAD: begin
                if (label_we) begin
                    load_cnt_next = load_cnt_reg + CNT_W'(1);
                end
                if (start) begin
                    tstate_next = T_RUN;
                end
            end
            T_RUN: begin
                if (res_ack) begin
                    m_valid_next          = 1'b1;
                    m_data_next.distance  = res.distance;
                    m_data_next.reachable = res.reachable;
                    load_cnt_next         = '0;
                    tstate_next           = T_LOAD;
                end
            end
            default: begin
                tstate_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tstate_reg   <= T_LOAD;
            load_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            tstate_reg   <= tstate_next;
            load_cnt_reg <= load_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // label store, written during load, read by the sweep sequencer
    lgmp_ram #(.WIDTH(LABEL_W), .DEPTH(CELLS)) u_label_ram (
        .aclk  (aclk),
        .we    (label_we),
        .waddr (load_cnt_reg[ADDR_W-1:0]),
        .wdata (s_data.label),
        .raddr (label_raddr),
        .rdata (label_rdata)
    );

    lgmp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .info        (info),
        .label_raddr (label_raddr),
        .label_rdata (label_rdata),
        .res         (res),
        .res_ack     (res_ack)
    );

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the layered manhattan distance transform block
// ----------------------------------------------------------------------------
// Grids of cell labels are queued by a stimulus process and sent on s_ by a
// clocked driver. A behavioral predictor stores each accepted cell and, on a
// cell with last set, computes the expected distance and reachable flag. A
// clocked monitor checks each result transaction against the oldest
// expectation. The geometry and the level count change between phases while
// the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import lgmp_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LABEL_W-1:0]   cfg_data;

    layered_grid_manhattan_path_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock, period 8
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // cells waiting for the driver, results waiting for the monitor
    in_item_t  cell_q[$];
    out_item_t result_q[$];

    int  errors    = 0;
    bit  no_idle   = 1'b0;   // set for a stretch with no idling on either side
    bit  hold_req  = 1'b0;   // asks the monitor for a long hold-off
    int  cells_made = 0;

    // ------------------------------------------------------------------
    // predictor state: its own copy of configuration, label store, costs
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   cfg_rows   = 7'd64;
    logic [DIM_W-1:0]   cfg_cols   = 7'd64;
    logic [LABEL_W-1:0] cfg_levels = 13'd1;

    logic [LABEL_W-1:0] grid_label [CELLS];
    int unsigned        grid_cost  [CELLS];
    int unsigned        grid_fill  = 0;
    bit                 level_seen [1 << LABEL_W];

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned step_sat(int unsigned v);
        return (v >= SAT_COST) ? SAT_COST : v + 1;
    endfunction

    // label of a cell; cells not loaded for this grid belong to no level
    function automatic int unsigned label_at(int unsigned k);
        return (k < grid_fill) ? grid_label[k] : 0;
    endfunction

    // one multi-source L1 transform from level v to the next level
    task automatic relax_level(int unsigned v, int unsigned nr, int unsigned nc);
        int unsigned k;
        int r, c;
        for (k = 0; k < nr * nc; k++)
            if (label_at(k) != v) grid_cost[k] = SAT_COST;
        for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++) begin
                k = r * nc + c;
                if (r > 0 && step_sat(grid_cost[k - nc]) < grid_cost[k])
                    grid_cost[k] = step_sat(grid_cost[k - nc]);
                if (c > 0 && step_sat(grid_cost[k - 1]) < grid_cost[k])
                    grid_cost[k] = step_sat(grid_cost[k - 1]);
            end
        for (r = nr - 1; r >= 0; r--)
            for (c = nc - 1; c >= 0; c--) begin
                k = r * nc + c;
                if (r + 1 < nr && step_sat(grid_cost[k + nc]) < grid_cost[k])
                    grid_cost[k] = step_sat(grid_cost[k + nc]);
                if (c + 1 < nc && step_sat(grid_cost[k + 1]) < grid_cost[k])
                    grid_cost[k] = step_sat(grid_cost[k + 1]);
            end
    endtask

    task automatic solve_grid(output out_item_t res);
        int unsigned nr, nc, n, p, k, v;
        bit all_there;
        nr = clamp_dim(cfg_rows, MAX_ROWS);
        nc = clamp_dim(cfg_cols, MAX_COLS);
        n  = nr * nc;
        p  = (cfg_levels == 0) ? 1 : cfg_levels;
        res.distance  = SAT_COST;
        res.reachable = 1'b0;
        foreach (level_seen[i]) level_seen[i] = 1'b0;
        for (k = 0; k < n; k++) level_seen[label_at(k)] = 1'b1;
        all_there = 1'b1;
        for (v = 1; v <= p; v++)
            if (!level_seen[v]) all_there = 1'b0;
        if (!all_there) return;
        for (k = 0; k < n; k++)
            grid_cost[k] = (label_at(k) == 1) ? (k / nc + k % nc) : SAT_COST;
        for (v = 1; v < p; v++) relax_level(v, nr, nc);
        for (k = 0; k < n; k++)
            if (label_at(k) == p) begin
                res.distance  = COST_W'((grid_cost[k] > SAT_COST) ? SAT_COST : grid_cost[k]);
                res.reachable = 1'b1;
                return;
            end
    endtask

    // store an accepted cell, and on last queue the expected result
    task automatic take_cell(in_item_t it);
        out_item_t res;
        int unsigned cap;
        cap = clamp_dim(cfg_rows, MAX_ROWS) * clamp_dim(cfg_cols, MAX_COLS);
        if (grid_fill < cap) begin
            grid_label[grid_fill] = it.label;
            grid_fill++;
        end
        if (it.last) begin
            solve_grid(res);
            result_q = {result_q, res};
            grid_fill = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: holds valid and payload until the transaction is accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) take_cell(s_data);
            if (s_valid && !s_ready) begin
                // stalled, keep offering
            end else if (cell_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 20)) begin
                s_data  <= cell_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back pressure, a long hold-off on request
    // ------------------------------------------------------------------
    int hold_cnt = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result distance=%0d reachable=%0b",
                             $time, m_data.distance, m_data.reachable);
                    errors++;
                end else begin
                    if (m_data.distance !== result_q[0].distance) begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, result_q[0].distance, m_data.distance);
                        errors++;
                    end
                    if (m_data.reachable !== result_q[0].reachable) begin
                        $display("%0t: reachable expected %0b actual %0b",
                                 $time, result_q[0].reachable, m_data.reachable);
                        errors++;
                    end
                    void'(result_q.pop_front());
                end
            end
            if (hold_req && hold_cnt == 0) begin
                hold_cnt <= 3000;
                m_ready  <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic wait_idle();
        while (cell_q.size() > 0 || s_valid || result_q.size() > 0) @(posedge aclk);
        // block may still be finishing a grid whose cells were dropped
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LABEL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROWS:   cfg_rows   = val[DIM_W-1:0];
            REG_COLS:   cfg_cols   = val[DIM_W-1:0];
            REG_LEVELS: cfg_levels = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(int r, int c, int p);
        wait_idle();
        write_reg(REG_ROWS, LABEL_W'(r));
        write_reg(REG_COLS, LABEL_W'(c));
        write_reg(REG_LEVELS, LABEL_W'(p));
        @(posedge aclk);
    endtask

    task automatic send_cell(logic [LABEL_W-1:0] lab, bit last);
        in_item_t it;
        it.label = lab;
        it.last  = last;
        cell_q = {cell_q, it};
        cells_made++;
    endtask

    // mode 0: well formed, 1: random labels, 2: short grid, 3: overlong grid
    task automatic send_grid(int mode);
        int unsigned nr, nc, n, p, cnt, k, j;
        logic [LABEL_W-1:0] lab [$];
        logic [LABEL_W-1:0] t;
        nr = clamp_dim(cfg_rows, MAX_ROWS);
        nc = clamp_dim(cfg_cols, MAX_COLS);
        n  = nr * nc;
        p  = (cfg_levels == 0) ? 1 : cfg_levels;
        cnt = n;
        if (mode == 2) cnt = $urandom_range(1, (n < 24) ? n : 24);
        if (mode == 3) cnt = n + $urandom_range(1, 4);
        for (k = 0; k < cnt; k++) begin
            if (mode == 1 || $urandom_range(0, 9) == 0)
                t = LABEL_W'($urandom_range(0, 8191));
            else if (k < p && mode == 0)
                t = LABEL_W'(k + 1);
            else
                t = LABEL_W'($urandom_range(1, (p < 8191) ? p : 8191));
            lab = {lab, t};
        end
        // scatter the guaranteed levels across the grid
        for (k = 0; k < cnt; k++) begin
            j = $urandom_range(0, cnt - 1);
            t = lab[k];
            lab[k] = lab[j];
            lab[j] = t;
        end
        for (k = 0; k < cnt; k++) send_cell(lab[k], k == cnt - 1);
    endtask

    initial begin
        int r, c, p, ph, g;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry, 64x64 with one level: short grids only
        send_cell(13'd1, 1'b1);
        send_cell(13'd0, 1'b0);
        send_cell(13'd4096, 1'b0);
        send_cell(13'd8191, 1'b0);
        send_cell(13'd1, 1'b1);
        // no label-1 cell: missing level
        send_cell(13'd2, 1'b0);
        send_cell(13'd2, 1'b1);

        // single cell grid, extra cells dropped including last
        set_grid(1, 1, 1);
        send_cell(13'd1, 1'b1);
        send_cell(13'd3, 1'b1);
        send_cell(13'd1, 1'b0);
        send_cell(13'd5, 1'b0);
        send_cell(13'd7, 1'b1);

        // zero registers act as one
        set_grid(0, 0, 0);
        send_cell(13'd1, 1'b1);

        // oversize dimensions clamp to the maximum, label above p fills only
        set_grid(127, 127, 2);
        send_cell(13'd3, 1'b0);
        send_cell(13'd2, 1'b0);
        send_cell(13'd1, 1'b0);
        send_cell(13'd2, 1'b1);

        // small multi-level grid, both orders of levels
        set_grid(2, 3, 3);
        send_cell(13'd3, 1'b0);
        send_cell(13'd2, 1'b0);
        send_cell(13'd1, 1'b0);
        send_cell(13'd1, 1'b0);
        send_cell(13'd2, 1'b0);
        send_cell(13'd3, 1'b1);

        // level count beyond any grid: always missing
        set_grid(3, 3, 8191);
        send_grid(1);

        // random phases
        ph = 0;
        while (cells_made < 1600) begin
            if (ph % 12 == 11) begin
                // large geometry, short grids and few levels keep it cheap
                r = ($urandom_range(0, 1) != 0) ? 64 : 127;
                c = $urandom_range(1, 127);
                p = $urandom_range(1, 2);
                set_grid(r, c, p);
                send_grid(2);
            end else begin
                r = $urandom_range(1, 8);
                c = $urandom_range(1, 8);
                case ($urandom_range(0, 9))
                    0:       p = 0;
                    1:       p = $urandom_range(9, 8191);
                    default: p = $urandom_range(1, (r * c < 6) ? r * c : 6);
                endcase
                set_grid(r, c, p);
                no_idle = (ph == 4);
                if (ph == 6) hold_req = 1'b1;
                for (g = 0; g < $urandom_range(3, 8); g++)
                    send_grid(($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3));
                if (ph == 6) begin
                    @(posedge aclk);
                    @(posedge aclk);
                    hold_req = 1'b0;
                end
            end
            ph++;
        end

        no_idle = 1'b0;
        while (cell_q.size() > 0 || s_valid || result_q.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #200000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/lgmp_pkg.sv
sv/lgmp_ram.sv
sv/lgmp_min_unit.sv
sv/lgmp_ctrl.sv
sv/layered_grid_manhattan_path_top.sv
dv/tb_top.sv
